FILE: hdl/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants, types and the scaling helper for the telemetry framer.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int unsigned PKT_SAMPLES = 20;
  localparam int unsigned RATE_BYTE   = 100;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned IDX_W    = 8;

  localparam logic [7:0] SYNC_HI     = 8'hAA;
  localparam logic [7:0] SYNC_LO     = 8'h55;
  localparam logic [7:0] FOOTER_BYTE = 8'h5A;
  localparam logic [7:0] PAD_BYTE    = 8'h00;
  localparam logic [7:0] SPP_BYTE    = 8'(PKT_SAMPLES);
  localparam logic [7:0] RATE_CONST  = 8'(RATE_BYTE);

  localparam logic signed [PROD_W-1:0] SCALE_PF = 32'sd100;
  localparam logic signed [PROD_W-1:0] SCALE_V  = 32'sd10;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Byte positions within the longest run of one item.
  localparam int unsigned POS_W           = 5;
  localparam logic [POS_W-1:0] POS_HEADER      = 5'd0;
  localparam logic [POS_W-1:0] POS_SAMPLE      = 5'd21;
  localparam logic [POS_W-1:0] POS_SAMPLE_LAST = 5'd26;
  localparam logic [POS_W-1:0] POS_FOOTER_LAST = 5'd30;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SET_OXYGEN,
    REG_SET_PEEP,
    REG_SET_RATE,
    REG_SET_TIDAL,
    REG_SET_RATIO
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  oxygen;
    logic [7:0]  peep;
    logic [7:0]  rate;
    logic [15:0] tidal;
    logic [7:0]  ratio;
  } cfg_t;

  typedef struct packed {
    logic                    hdr;
    logic                    ftr;
    logic [15:0]             pkt_cnt;
    logic [15:0]             err_code;
    logic [7:0]              oxy_int;
    logic [2:0][WORD_W-1:0]  word;
  } desc_t;

  // Divide by 256 truncating toward zero, then clamp to 16 bits.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0]   adj;
    logic signed [SAMPLE_W-1:0] q;
    adj = prod + (prod[PROD_W-1] ? 32'sd255 : 32'sd0);
    q   = SAMPLE_W'(adj >>> 8);
    if (q > 24'sd32767) begin
      sat_word = 16'h7FFF;
    end else if (q < -24'sd32768) begin
      sat_word = 16'h8000;
    end else begin
      sat_word = q[WORD_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/tpf_if.sv
// ----------------------------------------------------------------------------
// tpf_in_if / tpf_out_if
// Valid/ready channels for sample items and output bytes.
// ----------------------------------------------------------------------------
interface tpf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tpf_pkg::SAMPLE_W-1:0]   pressure_in;
  logic signed [tpf_pkg::SAMPLE_W-1:0]   airflow_in;
  logic signed [tpf_pkg::SAMPLE_W-1:0]   volume_in;
  logic [15:0]                           fault_code;
  logic [15:0]                           oxygen_level;

  modport source (output valid, pressure_in, airflow_in, volume_in, fault_code,
                  oxygen_level, input ready);
  modport sink   (input valid, pressure_in, airflow_in, volume_in, fault_code,
                  oxygen_level, output ready);
endinterface

interface tpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

FILE: hdl/telemetry_packet_framer.sv
// ----------------------------------------------------------------------------
// telemetry_packet_framer
// Frame sensor samples into a byte stream with packet headers and footers.
// ----------------------------------------------------------------------------
// Path: the first byte of an item passes the payload registers, the queue,
//   the current-item register and the output byte register.
// Throughput: one byte per cycle while an item is held and out_ch is ready; the
//   back part loads the next item only after the last byte of the current one.
// Reset (synchronous, rst_n low): clear packet position, packet count, queue,
//   output valid and all set point registers.
// ----------------------------------------------------------------------------
module telemetry_packet_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  tpf_in_if.sink                        in_ch,
  tpf_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  tpf_pkg::cfg_t     cfg_r, cfg_nxt;
  tpf_pkg::reg_idx_t reg_idx;
  tpf_pkg::desc_t    q_wdata, q_rdata;
  logic              q_push, q_pop, q_full, q_empty;
  logic              wr_en;

  // Register file: one word per set point, no wait states.
  assign pready  = 1'b1;
  assign reg_idx = tpf_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        tpf_pkg::REG_SET_OXYGEN: cfg_nxt.oxygen = pwdata[7:0];
        tpf_pkg::REG_SET_PEEP:   cfg_nxt.peep   = pwdata[7:0];
        tpf_pkg::REG_SET_RATE:   cfg_nxt.rate   = pwdata[7:0];
        tpf_pkg::REG_SET_TIDAL:  cfg_nxt.tidal  = pwdata[15:0];
        tpf_pkg::REG_SET_RATIO:  cfg_nxt.ratio  = pwdata[7:0];
        default:                 cfg_nxt        = cfg_r;  // drop unknown index
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tpf_pkg::REG_SET_OXYGEN: prdata = {24'd0, cfg_r.oxygen};
      tpf_pkg::REG_SET_PEEP:   prdata = {24'd0, cfg_r.peep};
      tpf_pkg::REG_SET_RATE:   prdata = {24'd0, cfg_r.rate};
      tpf_pkg::REG_SET_TIDAL:  prdata = {16'd0, cfg_r.tidal};
      tpf_pkg::REG_SET_RATIO:  prdata = {24'd0, cfg_r.ratio};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept the item, decide header and footer, scale the samples.
  tpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fifo_full  (q_full),
    .fifo_push  (q_push),
    .fifo_wdata (q_wdata)
  );

  // Queue: decouple the sample side from the byte side.
  tpf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: walk the byte positions of each item into the output register.
  tpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (q_empty),
    .fifo_rdata (q_rdata),
    .fifo_pop   (q_pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: hdl/tpf_front.sv
// ----------------------------------------------------------------------------
// tpf_front
// Accept samples, track packet position, scale and push descriptors.
// ----------------------------------------------------------------------------
module tpf_front (
  input  logic                clk,
  input  logic                rst_n,
  tpf_in_if.sink              in_ch,
  input  logic                fifo_full,
  output logic                fifo_push,
  output tpf_pkg::desc_t      fifo_wdata
);

  logic                              s1_vld_r, s1_vld_nxt;
  logic                              hdr_r, ftr_r;
  logic [15:0]                       pkt_r, err_r;
  logic [7:0]                        oxy_r;
  logic signed [tpf_pkg::PROD_W-1:0] prod_p_r, prod_a_r, prod_v_r;
  logic [tpf_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [15:0]                       cnt_r, cnt_nxt;
  logic [tpf_pkg::IDX_W:0]           idx_inc;
  logic                              take;
  logic                              is_hdr;

  assign fifo_push   = s1_vld_r && !fifo_full;
  assign in_ch.ready = !s1_vld_r || !fifo_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_hdr      = (idx_r == '0);
  assign idx_inc     = {1'b0, idx_r} + 9'd1;

  always_comb begin
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    s1_vld_nxt = s1_vld_r;
    if (fifo_push) begin
      s1_vld_nxt = 1'b0;
    end
    if (take) begin
      s1_vld_nxt = 1'b1;
      idx_nxt    = (idx_inc >= 9'(tpf_pkg::PKT_SAMPLES)) ? '0 : idx_inc[7:0];
      if (is_hdr) begin
        cnt_nxt = cnt_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      idx_r    <= '0;
      cnt_r    <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload stage: products registered before the clamp.
  always_ff @(posedge clk) begin
    if (take) begin
      hdr_r    <= is_hdr;
      ftr_r    <= (idx_r == 8'(tpf_pkg::PKT_SAMPLES - 1));
      pkt_r    <= cnt_r;
      err_r    <= in_ch.fault_code;
      oxy_r    <= in_ch.oxygen_level[15:8];
      prod_p_r <= tpf_pkg::PROD_W'(in_ch.pressure_in) * tpf_pkg::SCALE_PF;
      prod_a_r <= tpf_pkg::PROD_W'(in_ch.airflow_in) * tpf_pkg::SCALE_PF;
      prod_v_r <= tpf_pkg::PROD_W'(in_ch.volume_in) * tpf_pkg::SCALE_V;
    end
  end

  always_comb begin
    fifo_wdata          = '0;
    fifo_wdata.hdr      = hdr_r;
    fifo_wdata.ftr      = ftr_r;
    fifo_wdata.pkt_cnt  = pkt_r;
    fifo_wdata.err_code = err_r;
    fifo_wdata.oxy_int  = oxy_r;
    fifo_wdata.word[0]  = tpf_pkg::sat_word(prod_p_r);
    fifo_wdata.word[1]  = tpf_pkg::sat_word(prod_a_r);
    fifo_wdata.word[2]  = tpf_pkg::sat_word(prod_v_r);
  end

endmodule

FILE: hdl/tpf_fifo.sv
// ----------------------------------------------------------------------------
// tpf_fifo
// Short descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module tpf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpf_pkg::desc_t wdata,
  input  logic           pop,
  output tpf_pkg::desc_t rdata,
  output logic           full,
  output logic           empty
);

  tpf_pkg::desc_t                 mem_r [tpf_pkg::FIFO_DEPTH];
  logic [tpf_pkg::FIFO_AW-1:0]    wp_r, rp_r;
  logic [tpf_pkg::FIFO_AW:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (tpf_pkg::FIFO_AW+1)'(tpf_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: hdl/tpf_back.sv
// ----------------------------------------------------------------------------
// tpf_back
// Serialize one descriptor into header, sample and footer bytes.
// ----------------------------------------------------------------------------
module tpf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tpf_pkg::cfg_t  cfg,
  input  logic           fifo_empty,
  input  tpf_pkg::desc_t fifo_rdata,
  output logic           fifo_pop,
  tpf_out_if.source      out_ch
);

  tpf_pkg::desc_t                cur_r;
  logic                          busy_r, busy_nxt;
  logic [tpf_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic                          ovld_r, ovld_nxt;
  logic [7:0]                    obyte_r, byte_sel;
  logic                          olast_r;
  logic                          adv, emit, at_end;

  assign adv      = !ovld_r || out_ch.ready;
  assign emit     = busy_r && adv;
  assign fifo_pop = !busy_r && !fifo_empty;
  assign at_end   = (pos_r == (cur_r.ftr ? tpf_pkg::POS_FOOTER_LAST
                                         : tpf_pkg::POS_SAMPLE_LAST));

  assign out_ch.valid       = ovld_r;
  assign out_ch.out_byte    = obyte_r;
  assign out_ch.last_of_run = olast_r;

  always_comb begin
    case (pos_r)
      5'd0, 5'd2:                 byte_sel = tpf_pkg::SYNC_HI;
      5'd1, 5'd3:                 byte_sel = tpf_pkg::SYNC_LO;
      5'd4:                       byte_sel = cur_r.pkt_cnt[15:8];
      5'd5:                       byte_sel = cur_r.pkt_cnt[7:0];
      5'd6:                       byte_sel = tpf_pkg::RATE_CONST;
      5'd7:                       byte_sel = tpf_pkg::SPP_BYTE;
      5'd8:                       byte_sel = cur_r.err_code[15:8];
      5'd9:                       byte_sel = cur_r.err_code[7:0];
      5'd10:                      byte_sel = cfg.oxygen;
      5'd11:                      byte_sel = cfg.peep;
      5'd12:                      byte_sel = cfg.rate;
      5'd13:                      byte_sel = cfg.tidal[15:8];
      5'd14:                      byte_sel = cfg.tidal[7:0];
      5'd15:                      byte_sel = cfg.ratio;
      5'd20:                      byte_sel = cur_r.oxy_int;
      5'd21:                      byte_sel = cur_r.word[0][15:8];
      5'd22:                      byte_sel = cur_r.word[0][7:0];
      5'd23:                      byte_sel = cur_r.word[1][15:8];
      5'd24:                      byte_sel = cur_r.word[1][7:0];
      5'd25:                      byte_sel = cur_r.word[2][15:8];
      5'd26:                      byte_sel = cur_r.word[2][7:0];
      5'd27, 5'd28, 5'd29, 5'd30: byte_sel = tpf_pkg::FOOTER_BYTE;
      default:                    byte_sel = tpf_pkg::PAD_BYTE;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    ovld_nxt = ovld_r;
    if (fifo_pop) begin
      busy_nxt = 1'b1;
      pos_nxt  = fifo_rdata.hdr ? tpf_pkg::POS_HEADER : tpf_pkg::POS_SAMPLE;
    end
    if (emit) begin
      ovld_nxt = 1'b1;
      pos_nxt  = pos_r + 1'b1;
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (adv) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cur_r <= fifo_rdata;
    end
    if (emit) begin
      obyte_r <= byte_sel;
      olast_r <= at_end;
    end
  end

endmodule

FILE: sim/telemetry_packet_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_packet_framer_test
// Drive sensor samples and set point writes into the telemetry framer.
// Rebuild the expected byte stream (header, scaled words, footer) in a local
// framing model and compare every output byte and its end-of-item flag.
// ----------------------------------------------------------------------------
module telemetry_packet_framer_test;

  // Longest run of cycles in which neither channel moves an item.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cap on one random sender gap.
  localparam int unsigned MAX_GAP     = 60;
  // Settle time after the last byte.
  localparam int unsigned SETTLE      = 20;
  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [2:0]  REG_UNUSED  = 3'd5;
  localparam int unsigned PHASE_ITEMS = 55;

  typedef struct {
    logic signed [tpf_pkg::SAMPLE_W-1:0] pressure;
    logic signed [tpf_pkg::SAMPLE_W-1:0] airflow;
    logic signed [tpf_pkg::SAMPLE_W-1:0] volume;
    logic [15:0]                         err_code;
    logic [15:0]                         oxygen;
  } sample_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [tpf_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tpf_in_if  in_ch ();
  tpf_out_if out_ch ();

  telemetry_packet_framer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Framing model state: set points, slot within the packet, header count.
  tpf_pkg::cfg_t             set_points;
  logic [tpf_pkg::IDX_W-1:0] next_slot;
  logic [15:0]               header_count;

  // Bytes the framer still owes, oldest first.
  stream_byte_t    pending_bytes[$];

  int unsigned     mismatches;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framing model
  // ---------------------------------------------------------------------------

  // Scale by k, divide by 256 toward zero, clamp to a signed 16-bit word.
  function automatic logic [15:0] scaled_word(
    input logic signed [tpf_pkg::SAMPLE_W-1:0] raw,
    input longint k);
    longint quot;
    quot = (longint'(raw) * k) / 256;
    if (quot > 32767) quot = 32767;
    if (quot < -32768) quot = -32768;
    return quot[15:0];
  endfunction

  // Append every byte that one accepted sample must produce.
  function automatic void frame_sample(input sample_t s);
    logic [7:0] run[$];
    logic [15:0] w;
    if (next_slot == 0) begin
      run.push_back(tpf_pkg::SYNC_HI);
      run.push_back(tpf_pkg::SYNC_LO);
      run.push_back(tpf_pkg::SYNC_HI);
      run.push_back(tpf_pkg::SYNC_LO);
      run.push_back(header_count[15:8]);
      run.push_back(header_count[7:0]);
      run.push_back(tpf_pkg::RATE_CONST);
      run.push_back(tpf_pkg::SPP_BYTE);
      run.push_back(s.err_code[15:8]);
      run.push_back(s.err_code[7:0]);
      run.push_back(set_points.oxygen);
      run.push_back(set_points.peep);
      run.push_back(set_points.rate);
      run.push_back(set_points.tidal[15:8]);
      run.push_back(set_points.tidal[7:0]);
      run.push_back(set_points.ratio);
      repeat (4) run.push_back(tpf_pkg::PAD_BYTE);
      run.push_back(s.oxygen[15:8]);
      header_count = header_count + 16'd1;
    end
    w = scaled_word(s.pressure, 100);
    run.push_back(w[15:8]);
    run.push_back(w[7:0]);
    w = scaled_word(s.airflow, 100);
    run.push_back(w[15:8]);
    run.push_back(w[7:0]);
    w = scaled_word(s.volume, 10);
    run.push_back(w[15:8]);
    run.push_back(w[7:0]);
    if (next_slot == tpf_pkg::IDX_W'(tpf_pkg::PKT_SAMPLES - 1)) begin
      repeat (4) run.push_back(tpf_pkg::FOOTER_BYTE);
    end
    if (int'(next_slot) + 1 >= int'(tpf_pkg::PKT_SAMPLES)) next_slot = '0;
    else next_slot = next_slot + 1'b1;
    foreach (run[i]) pending_bytes.push_back('{run[i], i == run.size() - 1});
  endfunction

  // Mirror a register write; indexes past the map change nothing.
  function automatic void update_set_point(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      tpf_pkg::REG_SET_OXYGEN: set_points.oxygen = value[7:0];
      tpf_pkg::REG_SET_PEEP:   set_points.peep   = value[7:0];
      tpf_pkg::REG_SET_RATE:   set_points.rate   = value[7:0];
      tpf_pkg::REG_SET_TIDAL:  set_points.tidal  = value[15:0];
      tpf_pkg::REG_SET_RATIO:  set_points.ratio  = value[7:0];
      default: ;
    endcase
  endfunction

  // Value a register read must return; indexes past the map read zero.
  function automatic logic [31:0] expected_readback(input logic [2:0] idx);
    case (idx)
      tpf_pkg::REG_SET_OXYGEN: return {24'd0, set_points.oxygen};
      tpf_pkg::REG_SET_PEEP:   return {24'd0, set_points.peep};
      tpf_pkg::REG_SET_RATE:   return {24'd0, set_points.rate};
      tpf_pkg::REG_SET_TIDAL:  return {16'd0, set_points.tidal};
      tpf_pkg::REG_SET_RATIO:  return {24'd0, set_points.ratio};
      default:                 return '0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted sample, check every accepted byte.
  // Both channels are sampled at the rising edge, before any update lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_t      s;
    stream_byte_t exp_b;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        s.pressure = in_ch.pressure_in;
        s.airflow  = in_ch.airflow_in;
        s.volume   = in_ch.volume_in;
        s.err_code = in_ch.fault_code;
        s.oxygen   = in_ch.oxygen_level;
        frame_sample(s);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing pending", out_ch.out_byte));
        end else begin
          exp_b = pending_bytes.pop_front();
          if (out_ch.out_byte !== exp_b.data)
            report_mismatch($sformatf("out_byte got %02h expected %02h",
                                      out_ch.out_byte, exp_b.data));
          if (out_ch.last_of_run !== exp_b.last)
            report_mismatch($sformatf("last_of_run got %b expected %b (byte %02h)",
                                      out_ch.last_of_run, exp_b.last, exp_b.data));
        end
      end
    end
  end

  // Receiver: stall the byte stream at the current rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one sample after a random gap and hold it until accepted. Valid
  // stays high on return, so a back-to-back item is offered with valid never dropped.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pressure_in  <= s.pressure;
    in_ch.airflow_in   <= s.airflow;
    in_ch.volume_in    <= s.volume;
    in_ch.fault_code   <= s.err_code;
    in_ch.oxygen_level <= s.oxygen;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every owed byte has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  // Setup phase, access phase, then an idle phase that reads the register back.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tpf_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    update_set_point(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (prdata !== expected_readback(idx))
      report_mismatch($sformatf("prdata got %08h expected %08h (index %0d)",
                                prdata, expected_readback(idx), idx));
  endtask

  // Mix full-range readings with ones near each saturation knee and tiny ones.
  function automatic logic signed [tpf_pkg::SAMPLE_W-1:0] random_reading();
    case ($urandom_range(3))
      0: return tpf_pkg::SAMPLE_W'($urandom);
      1: return tpf_pkg::SAMPLE_W'(int'($urandom_range(180000)) - 90000);
      2: return tpf_pkg::SAMPLE_W'(int'($urandom_range(1800000)) - 900000);
      default: return tpf_pkg::SAMPLE_W'(int'($urandom_range(1200)) - 600);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.pressure = random_reading();
    s.airflow  = random_reading();
    s.volume   = random_reading();
    s.err_code = 16'($urandom);
    s.oxygen   = 16'($urandom);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One full packet at reset set points: range ends, rounding toward zero
  // on small negatives, and each side of both saturation knees.
  task automatic test_sample_extremes();
    int      levels [0:18];
    sample_t s;
    levels = '{8388607, -8388608, 0, -1, 1, 3, -3, 255, -255, 256, -256,
               83886, 83887, -83887, -83888, 838860, 838861, -838861, -838862};
    for (int i = 0; i < 19; i++) begin
      s.pressure = tpf_pkg::SAMPLE_W'(levels[i]);
      s.airflow  = tpf_pkg::SAMPLE_W'(levels[i]);
      s.volume   = tpf_pkg::SAMPLE_W'(levels[i]);
      // Header item carries all-ones error code and oxygen.
      s.err_code = (i == 0) ? 16'hFFFF : 16'h0000;
      s.oxygen   = (i == 0) ? 16'hFFFF : 16'h0000;
      send_sample(s);
    end
    // Close the packet with mixed signs so the footer follows.
    s.pressure = tpf_pkg::SAMPLE_W'(8388607);
    s.airflow  = tpf_pkg::SAMPLE_W'(-8388608);
    s.volume   = tpf_pkg::SAMPLE_W'(-1);
    send_sample(s);
    drain();
  endtask

  // All set points at their maximum, a dropped write past the map, and a
  // header whose oxygen reading has only fraction bits.
  task automatic test_set_point_extremes();
    sample_t s;
    write_reg(tpf_pkg::REG_SET_OXYGEN, 32'hFFFF_FFFF);
    write_reg(tpf_pkg::REG_SET_PEEP,   32'hFFFF_FFFF);
    write_reg(tpf_pkg::REG_SET_RATE,   32'hFFFF_FFFF);
    write_reg(tpf_pkg::REG_SET_TIDAL,  32'hFFFF_FFFF);
    write_reg(tpf_pkg::REG_SET_RATIO,  32'hFFFF_FFFF);
    write_reg(REG_UNUSED,              32'h0000_0000);
    for (int i = 0; i < int'(tpf_pkg::PKT_SAMPLES); i++) begin
      s = random_sample();
      if (i == 0) begin
        s.err_code = 16'h0000;
        s.oxygen   = 16'h00FF;
      end
      send_sample(s);
    end
    drain();
  endtask

  // Random packets under one idling pattern, with fresh set points first.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input bit zero_set_points);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(tpf_pkg::REG_SET_OXYGEN, zero_set_points ? 32'd0 : $urandom);
    write_reg(tpf_pkg::REG_SET_PEEP,   zero_set_points ? 32'd0 : $urandom);
    write_reg(tpf_pkg::REG_SET_RATE,   zero_set_points ? 32'd0 : $urandom);
    write_reg(tpf_pkg::REG_SET_TIDAL,  zero_set_points ? 32'd0 : $urandom);
    write_reg(tpf_pkg::REG_SET_RATIO,  zero_set_points ? 32'd0 : $urandom);
    write_reg(REG_UNUSED,              $urandom);
    repeat (PHASE_ITEMS) send_sample(random_sample());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero.
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.pressure_in  <= '0;
    in_ch.airflow_in   <= '0;
    in_ch.volume_in    <= '0;
    in_ch.fault_code   <= '0;
    in_ch.oxygen_level <= '0;
    set_points     = '0;
    next_slot      = '0;
    header_count   = '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sample_extremes();
    test_set_point_extremes();
    test_random_traffic(0, 0, 1'b0);
    test_random_traffic(79, 0, 1'b1);
    test_random_traffic(0, 79, 1'b0);
    test_random_traffic(30, 30, 1'b0);

    // Catch any stray bytes after the last expected one.
    repeat (SETTLE) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
